// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files
// no dependencies; included by modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ubx_ack_pkg.sv -----
// types, codes and frame constants for the acknowledge matcher
// no dependencies; used by ubx_ack_matcher
package ubx_ack_pkg;

    localparam int unsigned FRAME_LEN = 10;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned TICK_W    = 17;
    localparam int unsigned TMO_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [TICK_W-1:0] TICK_MAX    = 17'h1FFFF;
    localparam logic [TMO_W-1:0]  TMO_RESET   = 16'd3000;

    // fixed part of the acknowledge frame
    localparam logic [7:0] SYNC_1    = 8'hB5;
    localparam logic [7:0] SYNC_2    = 8'h62;
    localparam logic [7:0] ACK_CLASS = 8'h05;
    localparam logic [7:0] ACK_ID    = 8'h01;
    localparam logic [7:0] LEN_LO    = 8'h02;
    localparam logic [7:0] LEN_HI    = 8'h00;

    // constant parts of the two check sums, from the fixed bytes 2 to 5
    localparam logic [7:0] CKA_BASE = 8'h08;
    localparam logic [7:0] CKB_BASE = 8'h2B;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_BYTE   = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_UNUSED = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_IDLE    = 2'd0,
        STATUS_SEARCH  = 2'd1,
        STATUS_FOUND   = 2'd2,
        STATUS_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_CLASS     = 2'd0,
        CFG_ACK_ID        = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2,
        CFG_NONE          = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] match_position;
    } out_item_t;

    // frame byte expected at a given position
    function automatic logic [7:0] expected_byte(
        input logic [IDX_W-1:0] pos,
        input logic [7:0]       cls,
        input logic [7:0]       id
    );
        logic [7:0] result;
        begin
            case (pos)
                4'd0:    result = SYNC_1;
                4'd1:    result = SYNC_2;
                4'd2:    result = ACK_CLASS;
                4'd3:    result = ACK_ID;
                4'd4:    result = LEN_LO;
                4'd5:    result = LEN_HI;
                4'd6:    result = cls;
                4'd7:    result = id;
                4'd8:    result = CKA_BASE + cls + id;
                4'd9:    result = CKB_BASE + {cls[6:0], 1'b0} + id;
                default: result = SYNC_1;
            endcase
            return result;
        end
    endfunction

endpackage

// ----- rtl/ubx_ack_matcher.sv -----
// acknowledge frame matcher: input register, match logic, result register
// depends on ubx_ack_pkg and assert_macros.svh
//
// Usage: each input transaction on in_* carries a request type and a byte.
// A start request arms the matcher and clears the match position and the
// tick counter; received bytes advance through the ten-byte acknowledge
// frame (sync, class/id 05 01, length 2, awaited class and id, two check
// bytes); millisecond ticks count towards the timeout. Every input
// transaction yields exactly one output transaction with the status and
// the current match position.
// out_valid rises once the item has moved from the input register into the
// result register. Throughput is one transaction per cycle while out_stall
// does not hold the result register, through the single compare-and-update
// stage. When out_stall is high the result register holds, one further
// item waits in the input register, and in_stall is raised after that.
// Reset clears the valid flags of both registers, disarms the matcher and
// loads the register defaults (class 0, id 0, timeout 3000 ticks).
// Configuration writes on cfg_* take effect at once. The user must make
// them only while the block is idle; the block does not enforce this.
`include "assert_macros.svh"

module ubx_ack_matcher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  ubx_ack_pkg::in_item_t                in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output ubx_ack_pkg::out_item_t               out_data,
    input  logic                                 cfg_write,
    input  logic [ubx_ack_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ubx_ack_pkg::CFG_DAT_W-1:0]    cfg_data
);

    // configuration registers
    logic [7:0]                          ack_class_reg;
    logic [7:0]                          ack_id_reg;
    logic [ubx_ack_pkg::TMO_W-1:0]       timeout_ticks_reg;

    // matcher state
    logic                                armed_reg;
    logic                                armed_next;
    logic [ubx_ack_pkg::IDX_W-1:0]       match_index_reg;
    logic [ubx_ack_pkg::IDX_W-1:0]       match_index_next;
    logic [ubx_ack_pkg::TICK_W-1:0]      elapsed_reg;
    logic [ubx_ack_pkg::TICK_W-1:0]      elapsed_next;
    ubx_ack_pkg::status_t                status_next;

    // pipeline registers
    logic                                in_valid_reg;
    ubx_ack_pkg::in_item_t               in_data_reg;
    logic                                out_valid_reg;
    ubx_ack_pkg::out_item_t              out_data_reg;

    logic                                advance;
    logic                                in_take;
    logic [ubx_ack_pkg::TICK_W-1:0]      elapsed_inc;

    // handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_class_reg     <= 8'd0;
            ack_id_reg        <= 8'd0;
            timeout_ticks_reg <= ubx_ack_pkg::TMO_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ubx_ack_pkg::CFG_ACK_CLASS:     ack_class_reg     <= cfg_data[7:0];
                ubx_ack_pkg::CFG_ACK_ID:        ack_id_reg        <= cfg_data[7:0];
                ubx_ack_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // match and timeout logic for the transaction in the input register
    assign elapsed_inc = (elapsed_reg < ubx_ack_pkg::TICK_MAX) ?
                         elapsed_reg + 1'b1 : elapsed_reg;

    always_comb
    begin
        armed_next       = armed_reg;
        match_index_next = match_index_reg;
        elapsed_next     = elapsed_reg;
        status_next      = armed_reg ? ubx_ack_pkg::STATUS_SEARCH
                                     : ubx_ack_pkg::STATUS_IDLE;
        case (in_data_reg.req_type)
            ubx_ack_pkg::REQ_START:
            begin
                armed_next       = 1'b1;
                match_index_next = '0;
                elapsed_next     = '0;
                status_next      = ubx_ack_pkg::STATUS_SEARCH;
            end
            ubx_ack_pkg::REQ_BYTE:
            begin
                if (armed_reg)
                begin
                    if ((match_index_reg < ubx_ack_pkg::IDX_W'(ubx_ack_pkg::FRAME_LEN)) &&
                        (in_data_reg.rx_byte == ubx_ack_pkg::expected_byte(
                            match_index_reg, ack_class_reg, ack_id_reg)))
                        match_index_next = match_index_reg + 1'b1;
                    else
                        match_index_next = '0;
                    if (match_index_next >= ubx_ack_pkg::IDX_W'(ubx_ack_pkg::FRAME_LEN))
                    begin
                        match_index_next = ubx_ack_pkg::IDX_W'(ubx_ack_pkg::FRAME_LEN);
                        armed_next       = 1'b0;
                        status_next      = ubx_ack_pkg::STATUS_FOUND;
                    end
                    else
                        status_next = ubx_ack_pkg::STATUS_SEARCH;
                end
            end
            ubx_ack_pkg::REQ_TICK:
            begin
                if (armed_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > {1'b0, timeout_ticks_reg})
                    begin
                        armed_next  = 1'b0;
                        status_next = ubx_ack_pkg::STATUS_TIMEOUT;
                    end
                    else
                        status_next = ubx_ack_pkg::STATUS_SEARCH;
                end
            end
            default:
                ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            armed_reg       <= 1'b0;
            match_index_reg <= '0;
            elapsed_reg     <= '0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                armed_reg       <= armed_next;
                match_index_reg <= match_index_next;
                elapsed_reg     <= elapsed_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (advance)
        begin
            out_data_reg.status         <= status_next;
            out_data_reg.match_position <= match_index_next;
        end
    end

    // checks
    `ASSERT_ALWAYS(a_index_range, clk, rst_n,
        match_index_reg <= ubx_ack_pkg::IDX_W'(ubx_ack_pkg::FRAME_LEN),
        "match index beyond frame length")
    `ASSERT_IMPLIES(a_armed_index, clk, rst_n, armed_reg,
        match_index_reg < ubx_ack_pkg::IDX_W'(ubx_ack_pkg::FRAME_LEN),
        "armed with a complete frame")
    `ASSERT_IMPLIES(a_found_pos, clk, rst_n,
        out_valid_reg && (out_data_reg.status == ubx_ack_pkg::STATUS_FOUND),
        out_data_reg.match_position == ubx_ack_pkg::IDX_W'(ubx_ack_pkg::FRAME_LEN),
        "acknowledge reported short of a full frame")
    `ASSERT_NEXT(a_advance_out, clk, rst_n, advance, out_valid_reg,
        "processed transaction did not reach the result register")
    `ASSERT_NEXT(a_done_disarms, clk, rst_n,
        advance && ((status_next == ubx_ack_pkg::STATUS_FOUND) ||
                    (status_next == ubx_ack_pkg::STATUS_TIMEOUT)),
        !armed_reg,
        "matcher still armed after a final result")

endmodule
